// ===== rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Shared widths, register codes and inter-stage types of the periodic lattice
// neighbor index unit.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int CRD_W     = 6;   // coordinate
    localparam int EXT_W     = 7;   // extent register
    localparam int IDX_W     = 24;  // full site index
    localparam int SPA_W     = 18;  // spatial index
    localparam int SX_W      = 13;  // ey*ez, up to 64*64
    localparam int ST_W      = 19;  // ex*ey*ez, up to 64^3
    localparam int CFG_IDX_W = 2;

    localparam logic [EXT_W-1:0] MAX_EXTENT = EXT_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENT_T,
        REG_EXTENT_X,
        REG_EXTENT_Y,
        REG_EXTENT_Z
    } pli_reg_t;

    // saturated extents
    typedef struct packed {
        logic [EXT_W-1:0] et;
        logic [EXT_W-1:0] ex;
        logic [EXT_W-1:0] ey;
        logic [EXT_W-1:0] ez;
    } pli_ext_t;

    // per-direction wrap flags
    typedef struct packed {
        logic up_t;
        logic dn_t;
        logic up_x;
        logic dn_x;
        logic up_y;
        logic dn_y;
        logic up_z;
        logic dn_z;
    } pli_wrap_t;

    // index pipe to neighbor stage
    typedef struct packed {
        logic             err;
        pli_wrap_t        wrap;
        logic [IDX_W-1:0] site;
        logic [SPA_W-1:0] spatial;
        logic [ST_W-1:0]  st;
        logic [SX_W-1:0]  sx;
        logic [EXT_W-1:0] ez;
        logic [CRD_W-1:0] z;
        logic [IDX_W-1:0] t_off;
        logic [IDX_W-1:0] t_dn;
        logic [ST_W-1:0]  x_off;
        logic [ST_W-1:0]  x_dn;
        logic [SX_W-1:0]  y_off;
        logic [SX_W-1:0]  y_dn;
    } pli_nbr_t;

endpackage

// ===== rtl/pli_cfg.sv =====
// ----------------------------------------------------------------------------
// pli_cfg
// Extent registers with write port; presents extents saturated at MAX_EXTENT.
// ----------------------------------------------------------------------------
module pli_cfg
    import pli_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EXT_W-1:0]     cfg_data,
    output pli_ext_t             ext
);

    logic [EXT_W-1:0] extent_t_reg;
    logic [EXT_W-1:0] extent_x_reg;
    logic [EXT_W-1:0] extent_y_reg;
    logic [EXT_W-1:0] extent_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extent_t_reg <= EXT_W'(4);
            extent_x_reg <= EXT_W'(4);
            extent_y_reg <= EXT_W'(4);
            extent_z_reg <= EXT_W'(4);
        end else if (cfg_wr_en) begin
            unique case (pli_reg_t'(cfg_index))
                REG_EXTENT_T: extent_t_reg <= cfg_data;
                REG_EXTENT_X: extent_x_reg <= cfg_data;
                REG_EXTENT_Y: extent_y_reg <= cfg_data;
                REG_EXTENT_Z: extent_z_reg <= cfg_data;
            endcase
        end
    end

    assign ext.et = (extent_t_reg > MAX_EXTENT) ? MAX_EXTENT : extent_t_reg;
    assign ext.ex = (extent_x_reg > MAX_EXTENT) ? MAX_EXTENT : extent_x_reg;
    assign ext.ey = (extent_y_reg > MAX_EXTENT) ? MAX_EXTENT : extent_y_reg;
    assign ext.ez = (extent_z_reg > MAX_EXTENT) ? MAX_EXTENT : extent_z_reg;

endmodule

// ===== rtl/pli_index_pipe.sv =====
// ----------------------------------------------------------------------------
// pli_index_pipe
// Four-stage pipe: range check and wrap flags, strides, spatial index, site
// index and wrap offsets. Each stage holds its own valid bit.
// ----------------------------------------------------------------------------
module pli_index_pipe
    import pli_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  pli_ext_t         ext,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CRD_W-1:0] coord_t,
    input  logic [CRD_W-1:0] coord_x,
    input  logic [CRD_W-1:0] coord_y,
    input  logic [CRD_W-1:0] coord_z,
    output logic             out_valid,
    input  logic             out_ready,
    output pli_nbr_t         out_data
);

    // stage enables; a stage loads when empty or when its successor loads
    logic en1, en2, en3, en4;

    // ---- stage 1: range check, wrap flags
    logic             s1_valid_reg;
    logic [CRD_W-1:0] s1_t_reg, s1_x_reg, s1_y_reg, s1_z_reg;
    pli_ext_t         s1_ext_reg;
    logic             s1_err_reg;
    pli_wrap_t        s1_wrap_reg;
    logic             s1_err_next;
    pli_wrap_t        s1_wrap_next;

    // ---- stage 2: ey*ez stride, y offsets
    logic             s2_valid_reg;
    logic [CRD_W-1:0] s2_t_reg, s2_x_reg, s2_z_reg;
    logic [EXT_W-1:0] s2_et_reg, s2_ex_reg, s2_ez_reg;
    logic             s2_err_reg;
    pli_wrap_t        s2_wrap_reg;
    logic [SX_W-1:0]  s2_sx_reg, s2_zy_reg, s2_y_off_reg;
    logic [SX_W-1:0]  s2_sx_next, s2_y_off_next;

    // ---- stage 3: t stride, spatial index
    logic             s3_valid_reg;
    logic [CRD_W-1:0] s3_t_reg, s3_z_reg;
    logic [EXT_W-1:0] s3_et_reg, s3_ez_reg;
    logic             s3_err_reg;
    pli_wrap_t        s3_wrap_reg;
    logic [SX_W-1:0]  s3_sx_reg, s3_y_off_reg, s3_y_dn_reg;
    logic [ST_W-1:0]  s3_st_reg, s3_x_off_reg;
    logic [SPA_W-1:0] s3_spatial_reg;
    logic [ST_W-1:0]  s3_x_off_next;

    // ---- stage 4: site index, t offsets
    logic             s4_valid_reg;
    pli_nbr_t         s4_reg;
    pli_nbr_t         s4_next;

    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1
    always_comb begin
        s1_err_next = (EXT_W'(coord_t) >= ext.et) || (EXT_W'(coord_x) >= ext.ex) ||
                      (EXT_W'(coord_y) >= ext.ey) || (EXT_W'(coord_z) >= ext.ez);
        s1_wrap_next.up_t = (EXT_W'(coord_t) + EXT_W'(1)) >= ext.et;
        s1_wrap_next.up_x = (EXT_W'(coord_x) + EXT_W'(1)) >= ext.ex;
        s1_wrap_next.up_y = (EXT_W'(coord_y) + EXT_W'(1)) >= ext.ey;
        s1_wrap_next.up_z = (EXT_W'(coord_z) + EXT_W'(1)) >= ext.ez;
        s1_wrap_next.dn_t = (coord_t == '0);
        s1_wrap_next.dn_x = (coord_x == '0);
        s1_wrap_next.dn_y = (coord_y == '0);
        s1_wrap_next.dn_z = (coord_z == '0);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_t_reg    <= coord_t;
            s1_x_reg    <= coord_x;
            s1_y_reg    <= coord_y;
            s1_z_reg    <= coord_z;
            s1_ext_reg  <= ext;
            s1_err_reg  <= s1_err_next;
            s1_wrap_reg <= s1_wrap_next;
        end
    end

    // stage 2
    assign s2_sx_next    = SX_W'(SX_W'(s1_ext_reg.ey) * SX_W'(s1_ext_reg.ez));
    assign s2_y_off_next = SX_W'(SX_W'(s1_y_reg) * SX_W'(s1_ext_reg.ez));

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_t_reg     <= s1_t_reg;
            s2_x_reg     <= s1_x_reg;
            s2_z_reg     <= s1_z_reg;
            s2_et_reg    <= s1_ext_reg.et;
            s2_ex_reg    <= s1_ext_reg.ex;
            s2_ez_reg    <= s1_ext_reg.ez;
            s2_err_reg   <= s1_err_reg;
            s2_wrap_reg  <= s1_wrap_reg;
            s2_sx_reg    <= s2_sx_next;
            s2_y_off_reg <= s2_y_off_next;
            s2_zy_reg    <= SX_W'(s1_z_reg) + s2_y_off_next;
        end
    end

    // stage 3
    assign s3_x_off_next = ST_W'(ST_W'(s2_x_reg) * ST_W'(s2_sx_reg));

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_t_reg       <= s2_t_reg;
            s3_z_reg       <= s2_z_reg;
            s3_et_reg      <= s2_et_reg;
            s3_ez_reg      <= s2_ez_reg;
            s3_err_reg     <= s2_err_reg;
            s3_wrap_reg    <= s2_wrap_reg;
            s3_sx_reg      <= s2_sx_reg;
            s3_y_off_reg   <= s2_y_off_reg;
            s3_y_dn_reg    <= s2_sx_reg - SX_W'(s2_ez_reg);   // (ey-1)*ez
            s3_st_reg      <= ST_W'(ST_W'(s2_sx_reg) * ST_W'(s2_ex_reg));
            s3_x_off_reg   <= s3_x_off_next;
            s3_spatial_reg <= SPA_W'(s2_zy_reg) + SPA_W'(s3_x_off_next);
        end
    end

    // stage 4
    always_comb begin
        s4_next.err     = s3_err_reg;
        s4_next.wrap    = s3_wrap_reg;
        s4_next.t_off   = IDX_W'(IDX_W'(s3_t_reg) * IDX_W'(s3_st_reg));
        s4_next.site    = IDX_W'(s3_spatial_reg) + s4_next.t_off;
        s4_next.spatial = s3_spatial_reg;
        s4_next.st      = s3_st_reg;
        s4_next.sx      = s3_sx_reg;
        s4_next.ez      = s3_ez_reg;
        s4_next.z       = s3_z_reg;
        s4_next.t_dn    = IDX_W'(IDX_W'(s3_et_reg - EXT_W'(1)) * IDX_W'(s3_st_reg));
        s4_next.x_off   = s3_x_off_reg;
        s4_next.x_dn    = s3_st_reg - ST_W'(s3_sx_reg);         // (ex-1)*ey*ez
        s4_next.y_off   = s3_y_off_reg;
        s4_next.y_dn    = s3_y_dn_reg;
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_reg;

endmodule

// ===== rtl/pli_nbr_stage.sv =====
// ----------------------------------------------------------------------------
// pli_nbr_stage
// Last stage: eight neighbor indices by add or subtract of a stride or a wrap
// offset, error zeroing, output register.
// ----------------------------------------------------------------------------
module pli_nbr_stage
    import pli_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  pli_nbr_t         in_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_site_index,
    output logic [SPA_W-1:0] m_spatial_index,
    output logic [IDX_W-1:0] m_up_t,
    output logic [IDX_W-1:0] m_down_t,
    output logic [IDX_W-1:0] m_up_x,
    output logic [IDX_W-1:0] m_down_x,
    output logic [IDX_W-1:0] m_up_y,
    output logic [IDX_W-1:0] m_down_y,
    output logic [IDX_W-1:0] m_up_z,
    output logic [IDX_W-1:0] m_down_z,
    output logic             m_coord_error
);

    logic             valid_reg;
    logic             en;
    logic [IDX_W-1:0] site;
    logic [IDX_W-1:0] up_t_next, down_t_next, up_x_next, down_x_next;
    logic [IDX_W-1:0] up_y_next, down_y_next, up_z_next, down_z_next;
    logic [IDX_W-1:0] site_reg, up_t_reg, down_t_reg, up_x_reg, down_x_reg;
    logic [IDX_W-1:0] up_y_reg, down_y_reg, up_z_reg, down_z_reg;
    logic [SPA_W-1:0] spatial_reg;
    logic             err_reg;

    assign en       = !valid_reg || m_ready;
    assign in_ready = en;
    assign site     = in_data.site;

    // up wraps back by coord*stride, down wraps forward by (extent-1)*stride
    always_comb begin
        up_t_next   = in_data.wrap.up_t ? site - in_data.t_off
                                        : site + IDX_W'(in_data.st);
        down_t_next = in_data.wrap.dn_t ? site + in_data.t_dn
                                        : site - IDX_W'(in_data.st);
        up_x_next   = in_data.wrap.up_x ? site - IDX_W'(in_data.x_off)
                                        : site + IDX_W'(in_data.sx);
        down_x_next = in_data.wrap.dn_x ? site + IDX_W'(in_data.x_dn)
                                        : site - IDX_W'(in_data.sx);
        up_y_next   = in_data.wrap.up_y ? site - IDX_W'(in_data.y_off)
                                        : site + IDX_W'(in_data.ez);
        down_y_next = in_data.wrap.dn_y ? site + IDX_W'(in_data.y_dn)
                                        : site - IDX_W'(in_data.ez);
        up_z_next   = in_data.wrap.up_z ? site - IDX_W'(in_data.z)
                                        : site + IDX_W'(1);
        down_z_next = in_data.wrap.dn_z ? site + IDX_W'(in_data.ez - EXT_W'(1))
                                        : site - IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            err_reg <= in_data.err;
            if (in_data.err) begin
                site_reg    <= '0;
                spatial_reg <= '0;
                up_t_reg    <= '0;
                down_t_reg  <= '0;
                up_x_reg    <= '0;
                down_x_reg  <= '0;
                up_y_reg    <= '0;
                down_y_reg  <= '0;
                up_z_reg    <= '0;
                down_z_reg  <= '0;
            end else begin
                site_reg    <= site;
                spatial_reg <= in_data.spatial;
                up_t_reg    <= up_t_next;
                down_t_reg  <= down_t_next;
                up_x_reg    <= up_x_next;
                down_x_reg  <= down_x_next;
                up_y_reg    <= up_y_next;
                down_y_reg  <= down_y_next;
                up_z_reg    <= up_z_next;
                down_z_reg  <= down_z_next;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_site_index    = site_reg;
    assign m_spatial_index = spatial_reg;
    assign m_up_t          = up_t_reg;
    assign m_down_t        = down_t_reg;
    assign m_up_x          = up_x_reg;
    assign m_down_x        = down_x_reg;
    assign m_up_y          = up_y_reg;
    assign m_down_y        = down_y_reg;
    assign m_up_z          = up_z_reg;
    assign m_down_z        = down_z_reg;
    assign m_coord_error   = err_reg;

endmodule

// ===== rtl/periodic_lattice_neighbor_index_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_lattice_neighbor_index_unit
// Lexicographic index of a 4D lattice site and its eight periodic neighbors.
// ----------------------------------------------------------------------------
// Takes one site word (t, x, y, z) per cycle when not stalled, returns one
// result word per site: index z + Z*(y + Y*(x + X*t)), the spatial index
// z + Z*(y + Y*x) and the up/down neighbor indices in each direction, wrapped
// at the extents. Extents above 64 act as 64. If any coordinate is at or
// beyond its extent, coord_error is set and all indices read zero. Sustained
// rate is one word per cycle while m_ready stays high. There are five
// register stages, the first loaded at the accepting edge, with the
// stride multipliers (ey*ez, then times ex, then times t) each in a
// stage of their own, followed by the neighbor add/subtract stage. Every
// stage has its own valid bit, so empty stages fill while the output is
// stalled and s_ready only drops once all five stages hold words.
// Extents are written through cfg_wr_en/cfg_index/cfg_data (index 0..3 =
// t, x, y, z; reset value 4) and must only change while no word is in flight.
// ----------------------------------------------------------------------------
module periodic_lattice_neighbor_index_unit
    import pli_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EXT_W-1:0]     cfg_data,
    // site input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CRD_W-1:0]     s_coord_t,
    input  logic [CRD_W-1:0]     s_coord_x,
    input  logic [CRD_W-1:0]     s_coord_y,
    input  logic [CRD_W-1:0]     s_coord_z,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_site_index,
    output logic [SPA_W-1:0]     m_spatial_index,
    output logic [IDX_W-1:0]     m_up_t,
    output logic [IDX_W-1:0]     m_down_t,
    output logic [IDX_W-1:0]     m_up_x,
    output logic [IDX_W-1:0]     m_down_x,
    output logic [IDX_W-1:0]     m_up_y,
    output logic [IDX_W-1:0]     m_down_y,
    output logic [IDX_W-1:0]     m_up_z,
    output logic [IDX_W-1:0]     m_down_z,
    output logic                 m_coord_error
);

    pli_ext_t ext;          // saturated extents
    logic     pipe_valid;   // stage 4 holds a word
    logic     pipe_ready;   // output stage can take it
    pli_nbr_t pipe_data;

    // extent registers
    pli_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ext       (ext)
    );

    // stages 1-4: range check, strides, site index, wrap offsets
    pli_index_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ext       (ext),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .coord_t   (s_coord_t),
        .coord_x   (s_coord_x),
        .coord_y   (s_coord_y),
        .coord_z   (s_coord_z),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_data  (pipe_data)
    );

    // stage 5: neighbors and output register
    pli_nbr_stage u_nbr (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (pipe_valid),
        .in_ready        (pipe_ready),
        .in_data         (pipe_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_site_index    (m_site_index),
        .m_spatial_index (m_spatial_index),
        .m_up_t          (m_up_t),
        .m_down_t        (m_down_t),
        .m_up_x          (m_up_x),
        .m_down_x        (m_down_x),
        .m_up_y          (m_up_y),
        .m_down_y        (m_down_y),
        .m_up_z          (m_up_z),
        .m_down_z        (m_down_z),
        .m_coord_error   (m_coord_error)
    );

endmodule

// ===== rtl/pli_checker.sv =====
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks on the neighbor index unit, bound to the top level.
// ----------------------------------------------------------------------------
module pli_checker
    import pli_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [CRD_W-1:0]     s_coord_t,
    input logic [CRD_W-1:0]     s_coord_x,
    input logic [CRD_W-1:0]     s_coord_y,
    input logic [CRD_W-1:0]     s_coord_z,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [IDX_W-1:0]     m_site_index,
    input logic [SPA_W-1:0]     m_spatial_index,
    input logic [IDX_W-1:0]     m_up_t,
    input logic [IDX_W-1:0]     m_down_t,
    input logic [IDX_W-1:0]     m_up_x,
    input logic [IDX_W-1:0]     m_down_x,
    input logic [IDX_W-1:0]     m_up_y,
    input logic [IDX_W-1:0]     m_down_y,
    input logic [IDX_W-1:0]     m_up_z,
    input logic [IDX_W-1:0]     m_down_z,
    input logic                 m_coord_error
);

    // a waiting input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_coord_t) && $stable(s_coord_x)
                                && $stable(s_coord_y) && $stable(s_coord_z))
        else $error("input word changed while waiting");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_site_index)
                                && $stable(m_coord_error))
        else $error("output word changed while stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // error words carry zero indices
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_coord_error |-> m_site_index == '0 && m_spatial_index == '0
            && m_up_t == '0 && m_down_t == '0 && m_up_x == '0 && m_down_x == '0
            && m_up_y == '0 && m_down_y == '0 && m_up_z == '0 && m_down_z == '0)
        else $error("nonzero index on coordinate error");

    // site index extends the spatial index by t*X*Y*Z
    a_spatial_le_site: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_coord_error |-> IDX_W'(m_spatial_index) <= m_site_index)
        else $error("spatial index above site index");

endmodule

bind periodic_lattice_neighbor_index_unit pli_checker u_pli_checker (.*);

// ===== test/tb_periodic_lattice_neighbor_index_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_lattice_neighbor_index_unit
// Self-checking bench for the periodic lattice neighbor index unit.
// ----------------------------------------------------------------------------
// Sends lattice site words through the valid/ready input and checks every
// result word, field by field, against expectations worked out by an
// in-bench model of the lexicographic indexing and the periodic wrap. A
// directed table covers reset extents, out-of-range coordinates, extents of
// zero, one, 64 and above 64. Random phases follow, each with its own extents.
// Both ports idle at random, except for one quiet stretch.
// ----------------------------------------------------------------------------
module tb_periodic_lattice_neighbor_index_unit;
    import pli_pkg::*;

    localparam int STALL_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 55;
    localparam int IDLE_PERCENT = 11;
    localparam int MAX_PRINTS   = 40;

    // one expected result word
    typedef struct packed {
        logic [IDX_W-1:0] site;
        logic [SPA_W-1:0] spatial;
        logic [IDX_W-1:0] up_t;
        logic [IDX_W-1:0] down_t;
        logic [IDX_W-1:0] up_x;
        logic [IDX_W-1:0] down_x;
        logic [IDX_W-1:0] up_y;
        logic [IDX_W-1:0] down_y;
        logic [IDX_W-1:0] up_z;
        logic [IDX_W-1:0] down_z;
        logic             err;
    } nbr_result_t;

    // directed stimulus row; extents only used when new_cfg is set,
    // want only used when typed is set
    typedef struct packed {
        logic             new_cfg;
        logic [EXT_W-1:0] et, ex, ey, ez;
        logic [CRD_W-1:0] t, x, y, z;
        logic             typed;
        nbr_result_t      want;
    } site_row_t;

    // any coordinate out of range: indices zero, flag up
    localparam nbr_result_t RES_ERR  = '{err: 1'b1, default: '0};
    // every extent one: all neighbors are the origin itself
    localparam nbr_result_t RES_ZERO = '0;
    // 4^4 lattice, origin and far corner
    localparam nbr_result_t RES_ORIGIN_4 = '{
        site: 24'd0,   spatial: 18'd0,
        up_t: 24'd64,  down_t: 24'd192, up_x: 24'd16,  down_x: 24'd48,
        up_y: 24'd4,   down_y: 24'd12,  up_z: 24'd1,   down_z: 24'd3,
        err: 1'b0};
    localparam nbr_result_t RES_CORNER_4 = '{
        site: 24'd255, spatial: 18'd63,
        up_t: 24'd63,  down_t: 24'd191, up_x: 24'd207, down_x: 24'd239,
        up_y: 24'd243, down_y: 24'd251, up_z: 24'd252, down_z: 24'd254,
        err: 1'b0};

    localparam int DIR_N = 22;
    localparam site_row_t DIR_ROWS [DIR_N] = '{
        // reset extents 4,4,4,4
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1, RES_ORIGIN_4},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd3, 6'd3, 6'd3, 6'd3, 1'b1, RES_CORNER_4},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd1, 6'd2, 6'd3, 6'd0, 1'b0, RES_ZERO},
        // each coordinate just at its extent, then all at max
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd4, 6'd0, 6'd0, 6'd0, 1'b1, RES_ERR},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 6'd4, 6'd0, 6'd0, 1'b1, RES_ERR},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 6'd0, 6'd4, 6'd0, 1'b1, RES_ERR},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 6'd0, 6'd0, 6'd4, 1'b1, RES_ERR},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd63, 6'd63, 6'd63, 6'd63, 1'b1, RES_ERR},
        // full 64^4 lattice, widest indices
        '{1'b1, 7'd64, 7'd64, 7'd64, 7'd64, 6'd63, 6'd63, 6'd63, 6'd63, 1'b0, RES_ZERO},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0, RES_ZERO},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd42, 6'd21, 6'd42, 6'd21, 1'b0, RES_ZERO},
        // extent one everywhere
        '{1'b1, 7'd1, 7'd1, 7'd1, 7'd1, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1, RES_ZERO},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 6'd0, 6'd0, 6'd1, 1'b1, RES_ERR},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd63, 6'd0, 6'd0, 6'd0, 1'b1, RES_ERR},
        // zero extent: nothing is in range
        '{1'b1, 7'd0, 7'd4, 7'd4, 7'd4, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1, RES_ERR},
        // extents above 64 saturate
        '{1'b1, 7'd127, 7'd100, 7'd65, 7'd64, 6'd63, 6'd63, 6'd63, 6'd63, 1'b0, RES_ZERO},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 6'd10, 6'd20, 6'd30, 1'b0, RES_ZERO},
        // extent two: up and down land on the same site
        '{1'b1, 7'd2, 7'd2, 7'd2, 7'd2, 6'd1, 6'd0, 6'd1, 6'd0, 1'b0, RES_ZERO},
        // odd, mixed extents
        '{1'b1, 7'd2, 7'd3, 7'd5, 7'd7, 6'd1, 6'd2, 6'd4, 6'd6, 1'b0, RES_ZERO},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd1, 6'd3, 6'd0, 6'd0, 1'b1, RES_ERR},
        '{1'b1, 7'd64, 7'd1, 7'd64, 7'd1, 6'd63, 6'd0, 6'd63, 6'd0, 1'b0, RES_ZERO},
        '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 6'd1, 6'd0, 6'd0, 1'b1, RES_ERR}
    };

    // ------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    pli_reg_t         cfg_index = REG_EXTENT_T;
    logic [EXT_W-1:0] cfg_data  = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [CRD_W-1:0] s_coord_t = '0;
    logic [CRD_W-1:0] s_coord_x = '0;
    logic [CRD_W-1:0] s_coord_y = '0;
    logic [CRD_W-1:0] s_coord_z = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [IDX_W-1:0] m_site_index;
    logic [SPA_W-1:0] m_spatial_index;
    logic [IDX_W-1:0] m_up_t, m_down_t, m_up_x, m_down_x;
    logic [IDX_W-1:0] m_up_y, m_down_y, m_up_z, m_down_z;
    logic             m_coord_error;

    // shadow of the extent registers, reset values
    logic [EXT_W-1:0] ext_t_q = EXT_W'(4);
    logic [EXT_W-1:0] ext_x_q = EXT_W'(4);
    logic [EXT_W-1:0] ext_y_q = EXT_W'(4);
    logic [EXT_W-1:0] ext_z_q = EXT_W'(4);

    nbr_result_t pending_results [$];   // one entry per accepted site word
    logic        quiet         = 1'b0;  // no idling on either port
    int          mismatch_count  = 0;
    int          results_checked = 0;
    int          flagged_sites   = 0;
    int          extent_settings = 1;   // reset setting counts as one
    int          stall_cycles    = 0;

    periodic_lattice_neighbor_index_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_coord_t       (s_coord_t),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_coord_z       (s_coord_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_site_index    (m_site_index),
        .m_spatial_index (m_spatial_index),
        .m_up_t          (m_up_t),
        .m_down_t        (m_down_t),
        .m_up_x          (m_up_x),
        .m_down_x        (m_down_x),
        .m_up_y          (m_up_y),
        .m_down_y        (m_down_y),
        .m_up_z          (m_up_z),
        .m_down_z        (m_down_z),
        .m_coord_error   (m_coord_error)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Index model
    // ------------------------------------------------------------------
    function automatic int unsigned sat_extent(input logic [EXT_W-1:0] e);
        return (e > MAX_EXTENT) ? int'(MAX_EXTENT) : int'(e);
    endfunction

    // z fastest, t slowest; truncated to the index width
    function automatic logic [IDX_W-1:0] lex_index(input int unsigned t, x, y, z,
                                                   input int unsigned ex, ey, ez);
        return IDX_W'(z + ez * (y + ey * (x + ex * t)));
    endfunction

    function automatic int unsigned wrap_up(input int unsigned c, e);
        return (c + 1 >= e) ? 0 : c + 1;
    endfunction

    function automatic int unsigned wrap_down(input int unsigned c, e);
        return (c == 0) ? e - 1 : c - 1;
    endfunction

    function automatic nbr_result_t predict_neighbors(input logic [CRD_W-1:0] ct, cx,
                                                      input logic [CRD_W-1:0] cy, cz);
        nbr_result_t r;
        int unsigned et, ex, ey, ez, t, x, y, z;
        r  = '0;
        et = sat_extent(ext_t_q);
        ex = sat_extent(ext_x_q);
        ey = sat_extent(ext_y_q);
        ez = sat_extent(ext_z_q);
        t  = ct;
        x  = cx;
        y  = cy;
        z  = cz;
        // zero extent falls in here too: no coordinate is below zero
        if (t >= et || x >= ex || y >= ey || z >= ez) begin
            r.err = 1'b1;
            return r;
        end
        r.site    = lex_index(t, x, y, z, ex, ey, ez);
        r.spatial = SPA_W'(z + ez * (y + ey * x));
        r.up_t    = lex_index(wrap_up(t, et), x, y, z, ex, ey, ez);
        r.down_t  = lex_index(wrap_down(t, et), x, y, z, ex, ey, ez);
        r.up_x    = lex_index(t, wrap_up(x, ex), y, z, ex, ey, ez);
        r.down_x  = lex_index(t, wrap_down(x, ex), y, z, ex, ey, ez);
        r.up_y    = lex_index(t, x, wrap_up(y, ey), z, ex, ey, ez);
        r.down_y  = lex_index(t, x, wrap_down(y, ey), z, ex, ey, ez);
        r.up_z    = lex_index(t, x, y, wrap_up(z, ez), ex, ey, ez);
        r.down_z  = lex_index(t, x, y, wrap_down(z, ez), ex, ey, ez);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------
    // leans toward the corners: zero, one, 64, saturating, tiny lattices
    function automatic logic [EXT_W-1:0] pick_extent();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)  return '0;
        if (r < 10) return EXT_W'($urandom_range(65, 127));
        if (r < 20) return MAX_EXTENT;
        if (r < 30) return EXT_W'(1);
        if (r < 55) return EXT_W'($urandom_range(2, 6));
        return EXT_W'($urandom_range(1, 64));
    endfunction

    // mostly in range with the wrap points favored, a few anywhere
    function automatic logic [CRD_W-1:0] pick_coord(input logic [EXT_W-1:0] ext);
        int unsigned e, r;
        e = sat_extent(ext);
        r = $urandom_range(0, 99);
        if (e == 0 || r >= 96) return CRD_W'($urandom_range(0, 63));
        if (r < 20) return '0;
        if (r < 40) return CRD_W'(e - 1);
        return CRD_W'($urandom_range(0, e - 1));
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [IDX_W-1:0] got,
                               input logic [IDX_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      results_checked, name, got, want));
    endtask

    // result port: oldest pending expectation against each accepted word
    always @(posedge aclk) begin : result_monitor
        nbr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with no site word pending");
            end else begin
                want = pending_results.pop_front();
                check_field("site_index",    m_site_index,    want.site);
                check_field("spatial_index", IDX_W'(m_spatial_index),
                            IDX_W'(want.spatial));
                check_field("up_t",          m_up_t,          want.up_t);
                check_field("down_t",        m_down_t,        want.down_t);
                check_field("up_x",          m_up_x,          want.up_x);
                check_field("down_x",        m_down_x,        want.down_x);
                check_field("up_y",          m_up_y,          want.up_y);
                check_field("down_y",        m_down_y,        want.down_y);
                check_field("up_z",          m_up_z,          want.up_z);
                check_field("down_z",        m_down_z,        want.down_z);
                check_field("coord_error",   IDX_W'(m_coord_error), IDX_W'(want.err));
                results_checked++;
                if (want.err)
                    flagged_sites++;
            end
        end
    end

    // sink side: random back-pressure, none in the quiet stretch
    always @(negedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // watchdog: any handshake on either port restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     stall_cycles, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving; all tasks are entered at a falling edge and return at one
    // ------------------------------------------------------------------
    // one site word; valid is left high so a back-to-back word needs no
    // drop, and a random idle or drain_results lowers it
    task automatic send_site(input logic [CRD_W-1:0] t, x, y, z,
                             input nbr_result_t want);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_coord_t <= t;
        s_coord_x <= x;
        s_coord_y <= y;
        s_coord_z <= z;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(want);
        @(negedge aclk);
    endtask

    // stop sending and wait for every pending result word
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input pli_reg_t idx, input logic [EXT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_EXTENT_T: ext_t_q = value;
            REG_EXTENT_X: ext_x_q = value;
            REG_EXTENT_Y: ext_y_q = value;
            REG_EXTENT_Z: ext_z_q = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // only called with the pipe empty
    task automatic write_extents(input logic [EXT_W-1:0] et, ex, ey, ez);
        write_reg(REG_EXTENT_T, et);
        write_reg(REG_EXTENT_X, ex);
        write_reg(REG_EXTENT_Y, ey);
        write_reg(REG_EXTENT_Z, ez);
        cfg_wr_en <= 1'b0;
        extent_settings++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int i, p, k;
        site_row_t row;
        logic [CRD_W-1:0] t, x, y, z;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table, typed expectations where obvious
        for (i = 0; i < DIR_N; i++) begin
            row = DIR_ROWS[i];
            if (row.new_cfg) begin
                drain_results();
                write_extents(row.et, row.ex, row.ey, row.ez);
            end
            send_site(row.t, row.x, row.y, row.z,
                      row.typed ? row.want : predict_neighbors(row.t, row.x, row.y, row.z));
        end

        // random phases, each on fresh extents; phases 4 and 5 run with
        // no idling on either side
        for (p = 0; p < PHASES; p++) begin
            drain_results();
            write_extents(pick_extent(), pick_extent(), pick_extent(), pick_extent());
            quiet = (p == 4) || (p == 5);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                t = pick_coord(ext_t_q);
                x = pick_coord(ext_x_q);
                y = pick_coord(ext_y_q);
                z = pick_coord(ext_z_q);
                send_site(t, x, y, z, predict_neighbors(t, x, y, z));
            end
        end
        quiet = 1'b0;

        // drain, then a few pipe depths for any stray word
        drain_results();
        repeat (20) @(posedge aclk);

        $display("Summary: %0d result words checked, %0d flagged out of range, %0d extent settings",
                 results_checked, flagged_sites, extent_settings);
        $display("Summary: extents of zero, one, 64 and above 64 covered; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
